FILE: hw/rtl/sorted_timer_queue_top_macros.svh
// Assertion macros shared by the sorted timer queue RTL.
// Uses the clk and rst_n names of the including module.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define STQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define STQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stq_pkg.sv
// Types and constants of the sorted timer queue.
// No dependencies; used by the cell, the chain and the top level.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY = 1'b1;

  localparam logic [CFG_W-1:0] MAX_DELAY_RST = 31'd6000000;
  localparam logic [CFG_W-1:0] MIN_DELAY_RST = 31'd5;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_FIRE     = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [31:0]      fire_time;
    logic [CFG_W-1:0] period;
    logic             rep;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DECIDE,
    SEQ_CLAMP,
    SEQ_SUM,
    SEQ_INSERT,
    SEQ_DONE
  } seq_state_t;

endpackage

FILE: hw/rtl/stq_in_if.sv
// Input channel of the sorted timer queue: valid/ready plus one request.
// No dependencies.
`timescale 1ns / 1ps
interface stq_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [7:0]         task_id;
  logic signed [31:0] delay;
  logic               repeating;
  logic signed [31:0] now;

  modport source (output valid, op, task_id, delay, repeating, now, input ready);
  modport sink (input valid, op, task_id, delay, repeating, now, output ready);
endinterface

FILE: hw/rtl/stq_out_if.sv
// Result channel of the sorted timer queue: valid/ready plus one result.
// No dependencies; DEPTH sets the width of the occupancy field.
`timescale 1ns / 1ps
interface stq_out_if #(
  parameter int unsigned DEPTH = 16
);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               fired_valid;
  logic [7:0]         fired_task;
  logic               event_request;
  logic signed [31:0] next_fire_time;
  logic [CNT_W-1:0]   entries_used;

  modport source (output valid, status, fired_valid, fired_task, event_request,
                  next_fire_time, entries_used, input ready);
  modport sink (input valid, status, fired_valid, fired_task, event_request,
                next_fire_time, entries_used, output ready);
endinterface

FILE: hw/rtl/stq_cell.sv
// One slot of the sorted chain: holds an entry, takes from a neighbor.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       prev_keep,
  input  entry_t     left,
  input  entry_t     right,
  output entry_t     ent_r,
  output logic       keep
);

  entry_t ent_nxt;

  // slot stays put on insert when it is used and not later than the new entry
  assign keep = occ && ($signed(ent_r.fire_time) <= $signed(ctrl.ins.fire_time));

  always_comb begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (keep) begin
          ent_nxt = ent_r;
        end else if (prev_keep) begin
          ent_nxt = ctrl.ins;
        end else begin
          ent_nxt = left;
        end
      end
      CELL_POP: ent_nxt = right;
      default:  ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

FILE: hw/rtl/stq_chain.sv
// Row of DEPTH cells kept sorted by fire time, head at slot 0.
// Depends on stq_pkg and stq_cell.
`timescale 1ns / 1ps
module stq_chain
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] count,
  output entry_t           head,
  output logic             head_keep
);

  entry_t           ents [DEPTH];
  logic [DEPTH-1:0] keeps;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   prev_keep;

    if (i == 0) begin : g_first
      assign left_ent  = ctrl.ins;
      assign prev_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ents[i-1];
      assign prev_keep = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    stq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (count > CNT_W'(i)),
      .prev_keep (prev_keep),
      .left      (left_ent),
      .right     (right_ent),
      .ent_r     (ents[i]),
      .keep      (keeps[i])
    );
  end

  assign head      = ents[0];
  assign head_keep = keeps[0];

endmodule

FILE: hw/rtl/sorted_timer_queue_top.sv
// Sorted timer queue top level: request sequencer, cell chain, result register.
// Depends on stq_pkg, stq_in_if, stq_out_if, stq_chain and the macro header.
//
// Keeps up to DEPTH timer tasks ordered by absolute fire time in a chain of
// cells; every cell compares its own time with the new one in parallel, so
// an insert or a pop is a single update of the chain. A sequencer steps each
// transaction through decide, clamp, add and insert: a schedule that finds
// room and a fire of a repeating task take all of these steps; any other
// fire (or a rejected request) goes from decide straight to done, which
// waits while the result register holds a result not yet taken on out_chan.
// One transaction is in flight at a time; a finished result may wait in the
// output register while the next request is accepted. Configuration writes
// are taken at any time and are meant to happen only while the queue is idle.
`timescale 1ns / 1ps
`include "sorted_timer_queue_top_macros.svh"
module sorted_timer_queue_top
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  stq_in_if.sink               in_chan,
  stq_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  seq_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CFG_W-1:0] max_delay_r;
  logic [CFG_W-1:0] min_delay_r;

  logic             op_r;
  logic [7:0]       id_r;
  logic [31:0]      delay_r;
  logic             rep_r;
  logic [31:0]      now_r;
  logic [CFG_W-1:0] period_r;
  logic [31:0]      time_r;
  stat_t            status_r;
  logic             fired_valid_r;
  logic [7:0]       fired_id_r;
  logic             event_r;

  logic             out_valid_r;
  stat_t            out_status_r;
  logic             out_fired_valid_r;
  logic [7:0]       out_fired_id_r;
  logic             out_event_r;
  logic [31:0]      out_time_r;
  logic [CNT_W-1:0] out_used_r;

  cell_ctrl_t       ctrl;
  entry_t           head;
  logic             head_keep;
  logic             accept;
  logic             out_free;
  logic             load_out;
  logic             is_full;
  logic             is_empty;
  logic [CFG_W-1:0] clamped;

  stq_chain #(.DEPTH(DEPTH)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .count     (count_r),
    .head      (head),
    .head_keep (head_keep)
  );

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    if ($signed(delay_r) > $signed({1'b0, max_delay_r})) begin
      clamped = max_delay_r;
    end else if ($signed(delay_r) < $signed({1'b0, min_delay_r})) begin
      clamped = '0;
    end else begin
      clamped = delay_r[CFG_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = SEQ_DECIDE;
        end
      end
      SEQ_DECIDE: begin
        if (op_r == OP_SCHEDULE) begin
          state_nxt = is_full ? SEQ_DONE : SEQ_CLAMP;
        end else if (!is_empty && head.rep) begin
          state_nxt = SEQ_CLAMP;
        end else begin
          state_nxt = SEQ_DONE;
        end
      end
      SEQ_CLAMP:  state_nxt = SEQ_SUM;
      SEQ_SUM:    state_nxt = SEQ_INSERT;
      SEQ_INSERT: state_nxt = SEQ_DONE;
      SEQ_DONE: begin
        if (out_free) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = (state_r == SEQ_IDLE);
    load_out      = (state_r == SEQ_DONE) && out_free;
    ctrl.ins      = '{id: id_r, fire_time: time_r, period: period_r, rep: rep_r};
    if (state_r == SEQ_INSERT) begin
      ctrl.op = CELL_INSERT;
    end else if ((state_r == SEQ_DECIDE) && (op_r == OP_FIRE) && !is_empty) begin
      ctrl.op = CELL_POP;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      max_delay_r <= MAX_DELAY_RST;
      min_delay_r <= MIN_DELAY_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_DELAY: max_delay_r <= cfg_wdata;
          CFG_MIN_DELAY: min_delay_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctrl.op == CELL_POP) begin
        count_r <= count_r - CNT_W'(1);
      end else if (ctrl.op == CELL_INSERT) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r          <= in_chan.op;
      id_r          <= in_chan.task_id;
      delay_r       <= in_chan.delay;
      rep_r         <= in_chan.repeating;
      now_r         <= in_chan.now;
      status_r      <= STAT_OK;
      fired_valid_r <= 1'b0;
      fired_id_r    <= '0;
      event_r       <= 1'b0;
    end
    if (state_r == SEQ_DECIDE) begin
      if (op_r == OP_SCHEDULE) begin
        if (is_full) begin
          status_r <= STAT_FULL;
        end
      end else if (is_empty) begin
        status_r <= STAT_EMPTY;
      end else begin
        fired_valid_r <= 1'b1;
        fired_id_r    <= head.id;
        id_r          <= head.id;
        rep_r         <= head.rep;
        delay_r       <= {1'b0, head.period};
        event_r       <= (count_r > CNT_W'(1));
      end
    end
    if (state_r == SEQ_CLAMP) begin
      period_r <= clamped;
    end
    if (state_r == SEQ_SUM) begin
      time_r <= now_r + {1'b0, period_r};
    end
    if (state_r == SEQ_INSERT) begin
      event_r <= !head_keep;
    end
    if (load_out) begin
      out_status_r      <= status_r;
      out_fired_valid_r <= fired_valid_r;
      out_fired_id_r    <= fired_id_r;
      out_event_r       <= event_r;
      out_time_r        <= is_empty ? '0 : head.fire_time;
      out_used_r        <= count_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.fired_valid    = out_fired_valid_r;
  assign out_chan.fired_task     = out_fired_id_r;
  assign out_chan.event_request  = out_event_r;
  assign out_chan.next_fire_time = out_time_r;
  assign out_chan.entries_used   = out_used_r;

  `STQ_ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `STQ_ASSERT_IMPL(a_insert_room, state_r == SEQ_INSERT, !is_full, "insert into full chain")
  `STQ_ASSERT_IMPL(a_fire_ok, out_valid_r && out_fired_valid_r, out_status_r == STAT_OK,
                   "popped task with error status")
  `STQ_ASSERT_IMPL(a_used_match, $rose(out_valid_r), out_used_r == count_r,
                   "reported occupancy differs from count")

endmodule
